/* hw/rtl/gpa_pkg.sv */
// Shared types and constants of the goal priority arbiter.
`default_nettype none

package gpa_pkg;

  // Field widths fixed by the word formats.
  localparam int unsigned PosW     = 24;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned LimitW   = 5;
  localparam int unsigned LevelW   = 5;
  localparam int unsigned SqW      = 2 * PosW;
  localparam int unsigned ThrSqW   = 2 * CfgDataW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FOLLOW_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUEUE_LIMIT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHANGE_THRESH  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESEND_IVAL    = 2'd3;

  // Configuration reset values; the threshold is held squared.
  localparam logic [CfgDataW-1:0] FollowTimeoutRst = 16'd2000;
  localparam logic [LimitW-1:0]   QueueLimitRst    = 5'd10;
  localparam logic [ThrSqW-1:0]   ThrSqRst         = 32'd10000;
  localparam logic [CfgDataW-1:0] ResendIvalRst    = 16'd3000;

  // Input operation codes; codes above the last one do nothing.
  typedef enum logic [2:0] {
    FUNC_PRIO       = 3'd0,
    FUNC_FOLLOW     = 3'd1,
    FUNC_TICK       = 3'd2,
    FUNC_NAV_RESP   = 3'd3,
    FUNC_NAV_RESULT = 3'd4
  } func_e;

  // Navigator codes that count as accepted or successful.
  localparam logic [1:0] NAV_ACCEPTED = 2'd0;
  localparam logic [1:0] NAV_SUCCESS  = 2'd0;

  // Goal kinds.
  localparam logic KIND_FOLLOW = 1'b0;
  localparam logic KIND_PRIO   = 1'b1;

  typedef enum logic [1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_NAV    = 2'd1,
    MODE_IDLE   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_SEND   = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_e;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
  } pos_t;

  typedef struct packed {
    logic [2:0]             func;
    logic signed [PosW-1:0] goal_x;
    logic signed [PosW-1:0] goal_y;
    logic [TimeW-1:0]       now_ms;
    logic [1:0]             nav_code;
  } in_t;

  typedef struct packed {
    cmd_e                   command;
    logic                   goal_kind;
    logic signed [PosW-1:0] target_x;
    logic signed [PosW-1:0] target_y;
    mode_e                  mode_now;
    logic [LevelW-1:0]      queue_level;
    logic                   dropped;
    logic                   last;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/gpa_queue.sv */
// Storage of queued priority goals with a registered, write-first read port.
`default_nettype none

module gpa_queue #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire gpa_pkg::pos_t wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output gpa_pkg::pos_t      rdata_o
);

  gpa_pkg::pos_t mem_q [DEPTH];
  gpa_pkg::pos_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a write to the read address in the same cycle is passed through.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/goal_priority_arbiter_top.sv */
// An accepted word is held in the input register and processed from there; its first result
// is registered in the result buffer and offered from its front.
// Throughput: one word per cycle when each word gives one result and the output does not stall;
// a word that gives a cancel and a send holds the input while its two results go out one at a time.
// A tick that directly follows a word that moved the follow or sent position waits for the
// squared-distance registers to update. Reset clears all control state; queue entries need no clear.
`default_nettype none

module goal_priority_arbiter_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire gpa_pkg::in_t                    in_data_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output gpa_pkg::out_t                        out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [gpa_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [gpa_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > gpa_pkg::LimitW) ? CW : gpa_pkg::LimitW;
  localparam int unsigned SW = CW + 1;
  localparam int unsigned PW = gpa_pkg::PosW;

  // Input register.
  logic         in_valid_q;
  gpa_pkg::in_t in_q;

  // Configuration registers.
  logic [gpa_pkg::CfgDataW-1:0] timeout_q;
  logic [gpa_pkg::LimitW-1:0]   limit_q;
  logic [gpa_pkg::ThrSqW-1:0]   thr_sq_q;
  logic [gpa_pkg::CfgDataW-1:0] resend_q;

  // Arbiter state.
  gpa_pkg::mode_e          mode_q, mode_d;
  logic                    busy_q, busy_d;
  logic                    handle_q, handle_d;
  logic                    akind_q, akind_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    fseen_q, fseen_d;
  gpa_pkg::pos_t           fpos_q, fpos_d;
  logic [gpa_pkg::TimeW-1:0] fstamp_q, fstamp_d;
  gpa_pkg::pos_t           spos_q, spos_d;
  logic [gpa_pkg::TimeW-1:0] sstamp_q, sstamp_d;

  // Squared distance between the follow goal and the last sent goal.
  logic [gpa_pkg::SqW-1:0] dx2_q, dy2_q;
  logic                    pos_chg_q;
  logic signed [PW:0]      dxs, dys, dxn, dyn;
  logic [PW-1:0]           dxa, dya;

  // Result buffer.
  gpa_pkg::out_t res_q [2];
  logic [1:0]    ocnt_q;

  // Step outputs.
  logic          cancel_flag, send_flag, send_kind, drop, pos_upd, moved;
  gpa_pkg::pos_t send_pos;
  logic          q_we;
  logic [AW-1:0] q_waddr, q_raddr;
  gpa_pkg::pos_t q_wdata, q_rdata;
  gpa_pkg::out_t r0, r1;
  logic          two_res;

  // Handshake.
  logic pop, room, fire;

  assign pop         = out_valid_o && !out_stall_i;
  assign room        = (ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && pop);
  assign fire        = in_valid_q && room &&
                       !((in_q.func == gpa_pkg::FUNC_TICK) && pos_chg_q);
  assign in_stall_o  = in_valid_q && !fire;
  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_data_o  = res_q[0];

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Configuration writes; the change threshold is stored squared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= gpa_pkg::FollowTimeoutRst;
      limit_q   <= gpa_pkg::QueueLimitRst;
      thr_sq_q  <= gpa_pkg::ThrSqRst;
      resend_q  <= gpa_pkg::ResendIvalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gpa_pkg::CFG_FOLLOW_TIMEOUT: timeout_q <= cfg_wdata_i;
        gpa_pkg::CFG_QUEUE_LIMIT:    limit_q   <= cfg_wdata_i[gpa_pkg::LimitW-1:0];
        gpa_pkg::CFG_CHANGE_THRESH:  thr_sq_q  <= {16'b0, cfg_wdata_i} * {16'b0, cfg_wdata_i};
        gpa_pkg::CFG_RESEND_IVAL:    resend_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Absolute coordinate differences of the stored positions.
  always_comb begin
    dxs = {fpos_q.x[PW-1], fpos_q.x} - {spos_q.x[PW-1], spos_q.x};
    dys = {fpos_q.y[PW-1], fpos_q.y} - {spos_q.y[PW-1], spos_q.y};
    dxn = -dxs;
    dyn = -dys;
    dxa = dxs[PW] ? dxn[PW-1:0] : dxs[PW-1:0];
    dya = dys[PW] ? dyn[PW-1:0] : dys[PW-1:0];
  end

  // Squares are registered from the settled positions.
  always_ff @(posedge clk_i) begin
    dx2_q <= {{PW{1'b0}}, dxa} * {{PW{1'b0}}, dxa};
    dy2_q <= {{PW{1'b0}}, dya} * {{PW{1'b0}}, dya};
  end

  assign moved = ({1'b0, dx2_q} + {1'b0, dy2_q}) >
                 {{(gpa_pkg::SqW + 1 - gpa_pkg::ThrSqW){1'b0}}, thr_sq_q};

  // Queue storage, read ahead at the head the next word will see.
  assign q_raddr = fire ? head_d : head_q;
  assign q_wdata = '{x: in_q.goal_x, y: in_q.goal_y};

  gpa_queue #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (fire && q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  // One step of the arbiter for the word in the input register.
  always_comb begin : step_comb
    logic                      follow_ok;
    logic                      prio_pop;
    logic [gpa_pkg::TimeW-1:0] age_f, age_s;
    logic [LW-1:0]             lim;
    logic [AW-1:0]             head_inc, head_t;
    logic [CW-1:0]             cnt_t;
    logic [SW-1:0]             slot_sum;

    mode_d      = mode_q;
    busy_d      = busy_q;
    handle_d    = handle_q;
    akind_d     = akind_q;
    head_d      = head_q;
    count_d     = count_q;
    fseen_d     = fseen_q;
    fpos_d      = fpos_q;
    fstamp_d    = fstamp_q;
    spos_d      = spos_q;
    sstamp_d    = sstamp_q;
    cancel_flag = 1'b0;
    send_flag   = 1'b0;
    send_kind   = gpa_pkg::KIND_FOLLOW;
    send_pos    = fpos_q;
    drop        = 1'b0;
    q_we        = 1'b0;
    prio_pop    = 1'b0;

    age_f     = in_q.now_ms - fstamp_q;
    age_s     = in_q.now_ms - sstamp_q;
    follow_ok = fseen_q && (age_f <= {16'b0, timeout_q});
    head_inc  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);

    // Queue limit clamped to at least one and at most the storage depth.
    lim = LW'(limit_q);
    if (lim == '0) begin
      lim = LW'(1);
    end
    if (lim > LW'(QUEUE_DEPTH)) begin
      lim = LW'(QUEUE_DEPTH);
    end

    // Slot after an optional drop of the oldest entry.
    head_t = head_q;
    cnt_t  = count_q;
    if ((LW'(count_q) >= lim) && (count_q != '0)) begin
      head_t = head_inc;
      cnt_t  = count_q - CW'(1);
    end
    slot_sum = SW'(head_t) + SW'(cnt_t);
    if (slot_sum >= SW'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SW'(QUEUE_DEPTH);
    end
    q_waddr = slot_sum[AW-1:0];

    unique case (in_q.func)
      gpa_pkg::FUNC_PRIO: begin
        drop    = (cnt_t != count_q);
        q_we    = 1'b1;
        head_d  = head_t;
        count_d = cnt_t + CW'(1);
      end
      gpa_pkg::FUNC_FOLLOW: begin
        fpos_d   = q_wdata;
        fstamp_d = in_q.now_ms;
        fseen_d  = 1'b1;
      end
      gpa_pkg::FUNC_TICK: begin
        if (count_q != '0) begin
          // Queued goals take over the navigator.
          if (mode_q != gpa_pkg::MODE_NAV) begin
            mode_d      = gpa_pkg::MODE_NAV;
            cancel_flag = busy_q && handle_q;
          end
          prio_pop = !(busy_q && !cancel_flag);
        end else if (follow_ok) begin
          if (mode_q != gpa_pkg::MODE_FOLLOW) begin
            mode_d    = gpa_pkg::MODE_FOLLOW;
            sstamp_d  = in_q.now_ms;
            send_flag = 1'b1;
          end else if (!busy_q) begin
            if (moved) begin
              send_flag = 1'b1;
              sstamp_d  = in_q.now_ms;
            end
          end else if (age_s >= {16'b0, resend_q}) begin
            cancel_flag = moved && handle_q;
          end
        end else if (!(mode_q == gpa_pkg::MODE_NAV && busy_q)) begin
          if ((mode_q != gpa_pkg::MODE_IDLE) && !busy_q) begin
            mode_d = gpa_pkg::MODE_IDLE;
          end
        end
      end
      gpa_pkg::FUNC_NAV_RESP: begin
        if (in_q.nav_code == gpa_pkg::NAV_ACCEPTED) begin
          handle_d = 1'b1;
        end else begin
          busy_d = 1'b0;
        end
      end
      gpa_pkg::FUNC_NAV_RESULT: begin
        busy_d   = 1'b0;
        handle_d = 1'b0;
        if ((in_q.nav_code == gpa_pkg::NAV_SUCCESS) && (akind_q == gpa_pkg::KIND_PRIO)) begin
          if (count_q == '0) begin
            mode_d = gpa_pkg::MODE_FOLLOW;
          end else begin
            prio_pop = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // The head goal of the queue is sent.
    if (prio_pop) begin
      head_d    = head_inc;
      count_d   = count_q - CW'(1);
      send_flag = 1'b1;
      send_kind = gpa_pkg::KIND_PRIO;
      send_pos  = q_rdata;
    end

    if (cancel_flag) begin
      busy_d   = 1'b0;
      handle_d = 1'b0;
    end
    if (send_flag) begin
      busy_d  = 1'b1;
      akind_d = send_kind;
      spos_d  = send_pos;
    end

    pos_upd = (in_q.func == gpa_pkg::FUNC_FOLLOW) || send_flag;
  end

  // Result words: a cancel comes before a send.
  always_comb begin
    two_res        = cancel_flag && send_flag;

    r0.command     = cancel_flag ? gpa_pkg::CMD_CANCEL :
                     send_flag   ? gpa_pkg::CMD_SEND   : gpa_pkg::CMD_NONE;
    r0.goal_kind   = (send_flag && !cancel_flag) ? send_kind : 1'b0;
    r0.target_x    = (send_flag && !cancel_flag) ? send_pos.x : '0;
    r0.target_y    = (send_flag && !cancel_flag) ? send_pos.y : '0;
    r0.mode_now    = mode_d;
    r0.queue_level = gpa_pkg::LevelW'(count_d);
    r0.dropped     = drop;
    r0.last        = !two_res;

    r1.command     = gpa_pkg::CMD_SEND;
    r1.goal_kind   = send_kind;
    r1.target_x    = send_pos.x;
    r1.target_y    = send_pos.y;
    r1.mode_now    = mode_d;
    r1.queue_level = gpa_pkg::LevelW'(count_d);
    r1.dropped     = drop;
    r1.last        = 1'b1;
  end

  // Arbiter state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= gpa_pkg::MODE_FOLLOW;
      busy_q    <= 1'b0;
      handle_q  <= 1'b0;
      akind_q   <= gpa_pkg::KIND_FOLLOW;
      head_q    <= '0;
      count_q   <= '0;
      fseen_q   <= 1'b0;
      fpos_q    <= '0;
      fstamp_q  <= '0;
      spos_q    <= '0;
      sstamp_q  <= '0;
      pos_chg_q <= 1'b1;
    end else begin
      pos_chg_q <= fire && pos_upd;
      if (fire) begin
        mode_q   <= mode_d;
        busy_q   <= busy_d;
        handle_q <= handle_d;
        akind_q  <= akind_d;
        head_q   <= head_d;
        count_q  <= count_d;
        fseen_q  <= fseen_d;
        fpos_q   <= fpos_d;
        fstamp_q <= fstamp_d;
        spos_q   <= spos_d;
        sstamp_q <= sstamp_d;
      end
    end
  end

  // Result buffer of two words, drained from the front.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
    end else if (fire) begin
      ocnt_q <= two_res ? 2'd2 : 2'd1;
    end else if (pop) begin
      ocnt_q <= ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q[0] <= r0;
      res_q[1] <= r1;
    end else if (pop) begin
      res_q[0] <= res_q[1];
    end
  end

endmodule

`default_nettype wire
